FILE: design/edge_interval_capture_fifo_assert.svh
// Assertion macros used by the checker file of the edge interval capture block
`ifndef EDGE_INTERVAL_CAPTURE_FIFO_ASSERT_SVH
`define EDGE_INTERVAL_CAPTURE_FIFO_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define EICF_ASSERT_IMPLY(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define EICF_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/eicf_pkg.sv
// Package of shared types and constants for the edge interval capture block
`timescale 1ns / 1ps

package eicf_pkg;

    // Default ring depth in records (one slot always stays empty)
    localparam int RING_DEPTH_DEF = 32;

    localparam int TIME_W      = 32;
    localparam int FILL_W      = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 72;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_EDGE   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_ARM    = 2'd2,
        FUNC_DISARM = 2'd3
    } func_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } ctrl_cmd_t;

endpackage

FILE: design/eicf_ctrl.sv
// Controller state machine: sequences accept, execute and result load per transaction
`timescale 1ns / 1ps

module eicf_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output eicf_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESULT
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    // Output slot is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    // Drive datapath commands from the current state
    always_comb
    begin
        cmd.load_in  = s_tvalid && s_tready_reg;
        cmd.exec     = (state_reg == ST_EXEC);
        cmd.load_out = (state_reg == ST_RESULT) && out_free;
    end

    // Hold state and the handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // Raise valid on a result load, drop it once the result is taken
            if (cmd.load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid && s_tready_reg)
                    begin
                        s_tready_reg <= 1'b0;
                        state_reg    <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    if (out_free)
                    begin
                        s_tready_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg    <= ST_IDLE;
                    s_tready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: design/eicf_datapath.sv
// Datapath: capture state, record ring memory and result register
`timescale 1ns / 1ps

module eicf_datapath
#(
    parameter int RING_DEPTH = eicf_pkg::RING_DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  eicf_pkg::ctrl_cmd_t                 cmd,
    input  logic [1:0]                          s_tuser,
    input  logic [eicf_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic [0:0]                          m_tuser,
    output logic [eicf_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int REC_W = eicf_pkg::TIME_W + 1;

    // Input transaction register
    eicf_pkg::func_t             func_reg;
    logic                        level_in_reg;
    logic [eicf_pkg::TIME_W-1:0] time_in_reg;

    // Capture state
    logic [eicf_pkg::TIME_W-1:0] baseline_reg, baseline_next;
    logic [IDX_W-1:0]            wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]            rd_idx_reg, rd_idx_next;
    logic                        armed_reg, armed_next;
    logic [eicf_pkg::TIME_W-1:0] dropped_reg, dropped_next;
    logic                        hit_reg, hit_next;

    // Ring storage, {width, level}
    logic [REC_W-1:0]            ring_mem [RING_DEPTH];
    logic [REC_W-1:0]            rd_data_reg;
    logic                        ring_we;
    logic                        ring_re;

    logic [IDX_W-1:0]            wr_succ;
    logic [IDX_W-1:0]            rd_succ;
    logic [eicf_pkg::TIME_W-1:0] width_calc;
    logic [IDX_W:0]              fill_raw;
    logic [31:0]                 fill_wide;
    logic [eicf_pkg::TIME_W-1:0] pop_width;
    logic                        pop_level;

    logic [eicf_pkg::OUT_TDATA_W-1:0] out_tdata_reg;
    logic                             out_tuser_reg;

    // Latch the accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg     <= eicf_pkg::func_t'(s_tuser);
            level_in_reg <= s_tdata[0];
            time_in_reg  <= s_tdata[eicf_pkg::TIME_W:1];
        end
    end

    // Ring index successors with wrap at the depth
    assign wr_succ = (wr_idx_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_idx_reg + IDX_W'(1);
    assign rd_succ = (rd_idx_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : rd_idx_reg + IDX_W'(1);
    assign width_calc = time_in_reg - baseline_reg;

    // Work out the next capture state for the held transaction
    always_comb
    begin
        baseline_next = baseline_reg;
        wr_idx_next   = wr_idx_reg;
        rd_idx_next   = rd_idx_reg;
        armed_next    = armed_reg;
        dropped_next  = dropped_reg;
        hit_next      = hit_reg;
        ring_we       = 1'b0;
        ring_re       = 1'b0;
        if (cmd.exec)
        begin
            hit_next = 1'b0;
            case (func_reg)
                eicf_pkg::FUNC_EDGE:
                begin
                    if (armed_reg)
                    begin
                        baseline_next = time_in_reg;
                        if (wr_succ == rd_idx_reg)
                        begin
                            dropped_next = dropped_reg + 32'd1;
                        end
                        else
                        begin
                            ring_we     = 1'b1;
                            wr_idx_next = wr_succ;
                        end
                    end
                end
                eicf_pkg::FUNC_POP:
                begin
                    if (rd_idx_reg != wr_idx_reg)
                    begin
                        ring_re     = 1'b1;
                        hit_next    = 1'b1;
                        rd_idx_next = rd_succ;
                    end
                end
                eicf_pkg::FUNC_ARM:
                begin
                    baseline_next = time_in_reg;
                    wr_idx_next   = '0;
                    rd_idx_next   = '0;
                    armed_next    = 1'b1;
                end
                eicf_pkg::FUNC_DISARM:
                begin
                    armed_next = 1'b0;
                end
                default:
                begin
                    armed_next = armed_reg;
                end
            endcase
        end
    end

    // Hold capture state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg <= '0;
            wr_idx_reg   <= '0;
            rd_idx_reg   <= '0;
            armed_reg    <= 1'b0;
            dropped_reg  <= '0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            baseline_reg <= baseline_next;
            wr_idx_reg   <= wr_idx_next;
            rd_idx_reg   <= rd_idx_next;
            armed_reg    <= armed_next;
            dropped_reg  <= dropped_next;
            hit_reg      <= hit_next;
        end
    end

    // Write one record or read the oldest one
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wr_idx_reg] <= {width_calc, level_in_reg};
        end
        if (ring_re)
        begin
            rd_data_reg <= ring_mem[rd_idx_reg];
        end
    end

    // Records waiting in the ring
    always_comb
    begin
        if (wr_idx_reg >= rd_idx_reg)
        begin
            fill_raw = {1'b0, wr_idx_reg} - {1'b0, rd_idx_reg};
        end
        else
        begin
            fill_raw = {1'b0, wr_idx_reg} + (IDX_W + 1)'(RING_DEPTH) - {1'b0, rd_idx_reg};
        end
        fill_wide = 32'(fill_raw);
    end

    // Zero the popped fields when the pop found nothing
    assign pop_width = hit_reg ? rd_data_reg[REC_W-1:1] : '0;
    assign pop_level = hit_reg ? rd_data_reg[0] : 1'b0;

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_tuser_reg <= hit_reg;
            out_tdata_reg <= {1'b0, armed_reg, fill_wide[eicf_pkg::FILL_W-1:0],
                              dropped_reg, pop_width, pop_level};
        end
    end

    assign m_tuser = out_tuser_reg;
    assign m_tdata = out_tdata_reg;

endmodule

FILE: design/edge_interval_capture_fifo.sv
// Top level of the edge interval capture block with its record ring
// Usage:
//   Input stream (s_*): one transaction per item. s_tuser selects the kind:
//   edge, pop, arm or disarm. s_tdata carries the pin level and a microsecond
//   timestamp (baseline on arm). Arm loads the baseline, empties the ring and
//   enables capture; disarm stops capture but keeps queued records.
//   Each armed edge records the time since the previous edge (or the arm) and its level;
//   if the ring is full the record is dropped and the overrun count rises.
//   Output stream (m_*): exactly one transaction per input item. m_tuser
//   flags a pop that returned a record; m_tdata holds the record, the overrun
//   count, the fill count and the armed flag after the item.
//   Timing: an item is accepted, executed in the next cycle (ring write or
//   registered ring read), and its result is then loaded into the result
//   register, which raises m_tvalid; the next item is accepted only once
//   that load is done, so items are handled one at a time. A new item is
//   accepted while a result still waits.
//   A stalled receiver holds the result; a finished item then waits in the
//   block and no further item is accepted until the result is taken.
//   Reset clears the baseline, the ring indices, the overrun count and the
//   armed flag; the ring contents need no clearing.
`timescale 1ns / 1ps

module edge_interval_capture_fifo
#(
    parameter int RING_DEPTH = eicf_pkg::RING_DEPTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [1:0]                       s_tuser,  // func
    input  logic [eicf_pkg::IN_TDATA_W-1:0]  s_tdata,  // edge_level, time_us, zero pad
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [0:0]                       m_tuser,  // pop_valid
    output logic [eicf_pkg::OUT_TDATA_W-1:0] m_tdata   // pop_level, pop_width,
                                                       // overrun_count, fill_count,
                                                       // armed, zero pad
);

    eicf_pkg::ctrl_cmd_t cmd;

    // Sequence each transaction
    eicf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Capture state, ring and result register
    eicf_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .m_tuser (m_tuser),
        .m_tdata (m_tdata)
    );

endmodule

FILE: design/eicf_checker.sv
// Port-level checker for the edge interval capture block, bound to the top level
`timescale 1ns / 1ps
`include "edge_interval_capture_fifo_assert.svh"

module eicf_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [0:0]                       m_tuser,
    input logic [eicf_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic s_acc;
    logic m_stall;

    assign s_acc   = s_tvalid && s_tready;
    assign m_stall = m_tvalid && !m_tready;

    // One item in flight: input closes after each accepted transaction
    `EICF_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_acc, !s_tready, "input ready after accept")

    // A new result only appears while an item is being worked on
    `EICF_ASSERT_IMPLY(a_result_from_item, clk, rst_n, $rose(m_tvalid), $past(!s_tready),
        "result without an item in flight")

    // A stalled result holds
    `EICF_ASSERT_NEXT(a_stall_hold, clk, rst_n, m_stall,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // A result without a popped record carries a zero record
    `EICF_ASSERT_IMPLY(a_empty_pop_zero, clk, rst_n, m_tvalid && !m_tuser[0],
        m_tdata[eicf_pkg::TIME_W:0] == '0, "record fields set without pop_valid")

    // The pad bit above the armed flag stays clear
    `EICF_ASSERT_IMPLY(a_pad_zero, clk, rst_n, m_tvalid,
        m_tdata[eicf_pkg::OUT_TDATA_W-1] == 1'b0, "output pad bit set")

endmodule

bind edge_interval_capture_fifo eicf_checker u_eicf_checker (.*);
